FILE: hdl/bhcd_pkg.sv
// ----------------------------------------------------------------------------
// bhcd_pkg
// Constants, types and SHA-512 helper functions for hardened child derivation.
// ----------------------------------------------------------------------------
package bhcd_pkg;

   localparam int WORD_W = 64;
   localparam int INDEX_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Group order of the curve.
   localparam logic [255:0] ORDER_N =
      256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
   localparam logic [INDEX_W-1:0] HARD_BIT = 32'h8000_0000;
   localparam logic [INDEX_W-1:0] LAST_INDEX = 32'h7FFF_FFFF;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_W0 = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHAIN_W0 = 4'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_COUNT = 4'd8;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_HARDENED = 2'd1,
      ST_BAD_KEY = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned s);
      return (x >> s) | (x << (64 - s));
   endfunction

   function automatic logic [63:0] big_sigma0(input logic [63:0] x);
      return rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39);
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] x);
      return rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41);
   endfunction

   function automatic logic [63:0] small_sigma0(input logic [63:0] x);
      return rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] small_sigma1(input logic [63:0] x);
      return rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6);
   endfunction

   function automatic logic [63:0] hash_init(input logic [2:0] i);
      logic [63:0] r;
      case (i)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         default: r = 64'h5be0cd19137e2179;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] round_const(input logic [6:0] t);
      logic [63:0] r;
      case (t)
         7'd0: r = 64'h428a2f98d728ae22;  7'd1: r = 64'h7137449123ef65cd;
         7'd2: r = 64'hb5c0fbcfec4d3b2f;  7'd3: r = 64'he9b5dba58189dbbc;
         7'd4: r = 64'h3956c25bf348b538;  7'd5: r = 64'h59f111f1b605d019;
         7'd6: r = 64'h923f82a4af194f9b;  7'd7: r = 64'hab1c5ed5da6d8118;
         7'd8: r = 64'hd807aa98a3030242;  7'd9: r = 64'h12835b0145706fbe;
         7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
         7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
         7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
         7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
         7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
         7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
         7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
         7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
         7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
         7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
         7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
         7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
         7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
         7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
         7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
         7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
         7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
         7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
         7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
         7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
         7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
         7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
         7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
         7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
         7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
         7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
         7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
         7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
         7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
         7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
         7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
         7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
         7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
         7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
         7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
         default: r = 64'h0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/bip32_hardened_child_derive.sv
// ----------------------------------------------------------------------------
// bip32_hardened_child_derive
// Hardened child private-key derivation over HMAC-SHA512 with one hash memory.
// ----------------------------------------------------------------------------
// Usage: the parent key and chain code are written through the csr_ port
// (indexes 0..3 key, 4..7 chain code, most significant word first) while the
// block is idle. Each req_ transaction carries one child index. On success
// eight rsp_ transactions follow: child key words, then chain code words, with
// rsp_tlast on the eighth. An error gives a single transaction with a zero word.
// Operation: one attempt runs four SHA-512 blocks, each a state load from the
// hash memory, 80 rounds and a write-back, followed by the result read and
// modular add; a failed attempt retries with the next index. After the last
// attempt, words follow at one word per cycle while the receiver is ready. The
// single read port of the hash memory sets the load and write-back lengths.
// Only one child index is in flight; req_tready is high only between derives.
// Reset clears the control state and the key registers; the hash memory
// needs no clearing. When the receiver stalls, the word in the output
// register is held and the block waits.
// ----------------------------------------------------------------------------
module bip32_hardened_child_derive (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bhcd_pkg::INDEX_W-1:0]          req_tdata,  // child_index
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bhcd_pkg::WORD_W-1:0]           rsp_tdata,  // word
   output logic [7:0]                            rsp_tuser,  // status, word_select, zeros
   output logic                                  rsp_tlast,  // last
   input  logic                                  csr_we,
   input  logic [bhcd_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [bhcd_pkg::WORD_W-1:0]           csr_wdata
);
   import bhcd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_LOAD, S_ROUND, S_FINAL, S_MACRD, S_ADD, S_REDUCE, S_ZCHK, S_EMIT
   } state_type;

   state_type      state_ff, state_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [1:0]     blk_ff, blk_in;
   logic [31:0]    att_ff, att_in;
   logic [63:0]    v_ff [8];
   logic [63:0]    v_in [8];
   logic [63:0]    w_ff [16];
   logic [63:0]    w_in [16];
   logic [511:0]   mac_ff, mac_in;
   logic [256:0]   sum_ff, sum_in;
   logic [255:0]   child_ff, child_in;
   logic           il_ok_ff, il_ok_in;
   status_type     status_ff, status_in;
   logic [2:0]     sel_ff, sel_in;
   logic [255:0]   key_ff, chain_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_word_ff, rsp_word_in;
   status_type     rsp_status_ff, rsp_status_in;
   logic [2:0]     rsp_sel_ff, rsp_sel_in;
   logic           rsp_last_ff, rsp_last_in;

   // Hash memory: entries 0..7 inner chaining value, 8..15 outer chaining value.
   logic [63:0]    hash_mem [16];
   logic           mem_we;
   logic [3:0]     mem_waddr, mem_raddr;
   logic [63:0]    mem_wdata, mem_rdata_ff;

   logic           area;
   logic           first_blk;
   logic [1023:0]  msg_blk;
   logic [2:0]     d_idx;
   logic [63:0]    t1, t2, w_new;
   logic           load_rsp;
   logic           key_bad;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hash_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= hash_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         chain_ff <= '0;
      end else if (csr_we && csr_addr < CSR_COUNT) begin
         if (csr_addr < CSR_CHAIN_W0) begin
            key_ff[(3 - csr_addr[1:0]) * 64 +: 64] <= csr_wdata;
         end else begin
            chain_ff[(3 - csr_addr[1:0]) * 64 +: 64] <= csr_wdata;
         end
      end
   end

   assign area = blk_ff[1];
   assign first_blk = ~blk_ff[0];
   assign d_idx = 3'(cnt_ff - 7'd1);
   assign key_bad = (key_ff == '0) || (key_ff >= ORDER_N);

   always_comb begin
      case (blk_ff)
         2'd0: msg_blk = {chain_ff, 768'd0} ^ {128{8'h36}};
         2'd1: msg_blk = {8'h00, key_ff, att_ff | HARD_BIT, 8'h80, 656'd0, 64'd1320};
         2'd2: msg_blk = {chain_ff, 768'd0} ^ {128{8'h5c}};
         default: msg_blk = {512'd0, 8'h80, 440'd0, 64'd1536};
      endcase
   end

   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + round_const(cnt_ff) + w_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_new = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);

   assign load_rsp = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      mem_raddr = 4'd0;
      mem_we = 1'b0;
      mem_waddr = {area, d_idx};
      mem_wdata = (first_blk ? hash_init(d_idx) : mem_rdata_ff) + v_ff[d_idx];
      case (state_ff)
         S_LOAD: begin
            if (cnt_ff < 7'd8) begin
               mem_raddr = {area, 3'(3'd7 - cnt_ff[2:0])};
            end else begin
               mem_raddr = {1'b0, cnt_ff[2:0]};
            end
         end
         S_FINAL: begin
            mem_raddr = {area, cnt_ff[2:0]};
            mem_we = (cnt_ff != 7'd0);
         end
         S_MACRD: begin
            mem_raddr = {1'b1, cnt_ff[2:0]};
         end
         default: begin
            mem_raddr = 4'd0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      blk_in = blk_ff;
      att_in = att_ff;
      v_in = v_ff;
      w_in = w_ff;
      mac_in = mac_ff;
      sum_in = sum_ff;
      child_in = child_ff;
      il_ok_in = il_ok_ff;
      status_in = status_ff;
      sel_in = sel_ff;
      rsp_word_in = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sel_in = rsp_sel_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || load_rsp;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               att_in = req_tdata;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            sel_in = 3'd0;
            if ((att_ff & HARD_BIT) != '0) begin
               status_in = ST_HARDENED;
               state_in = S_EMIT;
            end else if (key_bad) begin
               status_in = ST_BAD_KEY;
               state_in = S_EMIT;
            end else begin
               status_in = ST_OK;
               blk_in = 2'd0;
               cnt_in = 7'd0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (cnt_ff == 7'd0) begin
               for (int j = 0; j < 16; j++) begin
                  w_in[j] = msg_blk[1023 - 64 * j -: 64];
               end
            end else if (cnt_ff <= 7'd8) begin
               for (int k = 7; k > 0; k--) begin
                  v_in[k] = v_ff[k-1];
               end
               v_in[0] = first_blk ? hash_init(3'(3'd7 - d_idx)) : mem_rdata_ff;
            end else if (blk_ff == 2'd3) begin
               // Second outer block carries the inner digest as its message.
               w_in[{1'b0, d_idx}] = mem_rdata_ff;
            end
            if (cnt_ff == 7'd16) begin
               cnt_in = 7'd0;
               state_in = S_ROUND;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_ROUND: begin
            for (int k = 7; k > 0; k--) begin
               v_in[k] = v_ff[k-1];
            end
            v_in[4] = v_ff[3] + t1;
            v_in[0] = t1 + t2;
            for (int j = 0; j < 15; j++) begin
               w_in[j] = w_ff[j+1];
            end
            w_in[15] = w_new;
            if (cnt_ff == 7'd79) begin
               cnt_in = 7'd0;
               state_in = S_FINAL;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_FINAL: begin
            if (cnt_ff == 7'd8) begin
               cnt_in = 7'd0;
               if (blk_ff == 2'd3) begin
                  state_in = S_MACRD;
               end else begin
                  blk_in = blk_ff + 2'd1;
                  state_in = S_LOAD;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_MACRD: begin
            if (cnt_ff != 7'd0) begin
               mac_in[(3'd7 - d_idx) * 64 +: 64] = mem_rdata_ff;
            end
            if (cnt_ff == 7'd8) begin
               cnt_in = 7'd0;
               state_in = S_ADD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_ADD: begin
            sum_in = {1'b0, mac_ff[511:256]} + {1'b0, key_ff};
            il_ok_in = mac_ff[511:256] < ORDER_N;
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (sum_ff >= {1'b0, ORDER_N}) begin
               child_in = 256'(sum_ff - {1'b0, ORDER_N});
            end else begin
               child_in = sum_ff[255:0];
            end
            state_in = S_ZCHK;
         end
         S_ZCHK: begin
            sel_in = 3'd0;
            if (il_ok_ff && child_ff != '0) begin
               status_in = ST_OK;
               state_in = S_EMIT;
            end else if (att_ff == LAST_INDEX) begin
               status_in = ST_EXHAUSTED;
               state_in = S_EMIT;
            end else begin
               att_in = att_ff + 32'd1;
               blk_in = 2'd0;
               cnt_in = 7'd0;
               state_in = S_LOAD;
            end
         end
         S_EMIT: begin
            if (load_rsp) begin
               rsp_status_in = status_ff;
               if (status_ff != ST_OK) begin
                  rsp_word_in = '0;
                  rsp_sel_in = 3'd0;
                  rsp_last_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rsp_sel_in = sel_ff;
                  if (!sel_ff[2]) begin
                     rsp_word_in = child_ff[(2'd3 - sel_ff[1:0]) * 64 +: 64];
                  end else begin
                     rsp_word_in = mac_ff[(2'd3 - sel_ff[1:0]) * 64 +: 64];
                  end
                  rsp_last_in = (sel_ff == 3'd7);
                  sel_in = sel_ff + 3'd1;
                  if (sel_ff == 3'd7) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         blk_ff <= '0;
         status_ff <= ST_OK;
         sel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         blk_ff <= blk_in;
         status_ff <= status_in;
         sel_ff <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      att_ff <= att_in;
      v_ff <= v_in;
      w_ff <= w_in;
      mac_ff <= mac_in;
      sum_ff <= sum_in;
      child_ff <= child_in;
      il_ok_ff <= il_ok_in;
      rsp_word_ff <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sel_ff <= rsp_sel_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_word_ff;
   assign rsp_tuser = {3'b000, rsp_sel_ff, rsp_status_ff};
   assign rsp_tlast = rsp_last_ff;

   // An error transaction is always the only one of its derive.
   a_err_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_last_ff && rsp_sel_ff == 3'd0)
      else $error("error transaction not single");

   // A successful derive ends on the last chain code word.
   a_ok_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_OK && rsp_last_ff |-> rsp_sel_ff == 3'd7)
      else $error("derive ended on wrong word");

   // Once an index is taken, no further index is taken in the next cycle.
   a_one_inflight : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second index accepted while busy");

endmodule
